// ===== rtl/cgfs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgfs_pkg: shared types and constants
// Widths, register indexes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package cgfs_pkg;

  localparam int unsigned NumberBitsDef = 32;
  localparam int unsigned CoeffW        = 6;
  localparam int unsigned StepW         = 15;
  localparam int unsigned DivW          = 32;
  localparam int unsigned TestsW        = 21;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 32;

  localparam logic [CfgIdxW-1:0] RegMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCoefLo = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCoefHi = 2'd2;

  localparam logic [CoeffW-1:0] CoefLoRst = 6'd2;
  localparam logic [CoeffW-1:0] CoefHiRst = 6'd31;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // latch number, clear counters, start sqrt
    logic sqrt_step;  // one sqrt digit
    logic start_coef; // set a = first coefficient, t = 1, own = 0
    logic next_coef;  // a++, t = 1, own = 0
    logic form_arg;   // compute a*t*t-1 (two multiply stages)
    logic gcd_init;   // x = n, y = arg
    logic gcd_step;   // one remainder bit step
    logic count;      // tests++, own++
    logic next_t;     // t++
  } cgfs_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic trivial;    // n < 4 or range empty
    logic sqrt_done;
    logic t_over;     // t > max_t
    logic gcd_done;   // y == 0 and no division running
    logic hit;        // 1 < g < n
    logic a_last;     // a == hi
    logic mul_done;
  } cgfs_sts_t;

endpackage
`default_nettype wire

// ===== rtl/cgfs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgfs_if: valid/ready channels
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface cgfs_in_if #(parameter int unsigned NumberBits = 32);
  logic                  valid;
  logic                  ready;
  logic [NumberBits-1:0] number;
  modport source (output valid, number, input ready);
  modport sink   (input valid, number, output ready);
endinterface

interface cgfs_out_if;
  import cgfs_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [CoeffW-1:0] coefficient;
  logic [StepW-1:0]  hit_step;
  logic [DivW-1:0]   divisor;
  logic [TestsW-1:0] tests_made;
  logic              last;
  modport source (output valid, found, coefficient, hit_step, divisor, tests_made, last,
                  input ready);
  modport sink   (input valid, found, coefficient, hit_step, divisor, tests_made, last,
                  output ready);
endinterface

interface cgfs_cfg_if;
  import cgfs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cgfs_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgfs_datapath: search datapath
// Bit-serial sqrt, argument multiplier, restoring-division gcd, counters.
// ----------------------------------------------------------------------------
module cgfs_datapath import cgfs_pkg::*; #(
  parameter int unsigned NumberBits = NumberBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cgfs_cmd_t         cmd_i,
  output      cgfs_sts_t         sts_o,
  input  wire logic [NumberBits-1:0] number_i,
  input  wire logic [CoeffW-1:0] lo_i,
  input  wire logic [CoeffW-1:0] hi_i,
  output      logic [CoeffW-1:0] a_o,
  output      logic [StepW-1:0]  t_o,
  output      logic [DivW-1:0]   g_o,
  output      logic [TestsW-1:0] tests_o,
  output      logic [TestsW-1:0] own_o
);
  localparam int unsigned NW   = NumberBits;
  localparam int unsigned RW   = (NW + 1) / 2;        // sqrt width
  localparam int unsigned TW   = RW;                  // t width (t <= max_t+1)
  localparam int unsigned AW   = CoeffW + 2 * TW;     // a*t*t width
  localparam int unsigned SqCW = $clog2(RW + 1);

  logic [NW-1:0] n_q;
  logic [CoeffW-1:0] lo_eff;
  assign lo_eff = (lo_i == '0) ? CoeffW'(1) : lo_i;

  // bit-serial integer square root, two bits of n per step
  logic [NW+1:0] srem_q, srem_d;
  logic [RW-1:0] sres_q;
  logic [SqCW-1:0] scnt_q;
  logic [NW+1:0] strial;
  logic [NW+1:0] stop_bits;
  assign stop_bits = {2'b00, n_q} >> (2 * (scnt_q - SqCW'(1)));
  assign srem_d    = {srem_q[NW-1:0], stop_bits[1:0]};
  assign strial    = (NW+2)'({sres_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
    end else if (cmd_i.load) begin
      scnt_q <= SqCW'(RW);
    end else if (cmd_i.sqrt_step && scnt_q != '0) begin
      scnt_q <= scnt_q - SqCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= number_i;
      srem_q <= '0;
      sres_q <= '0;
    end else if (cmd_i.sqrt_step && scnt_q != '0) begin
      if (srem_d >= strial) begin
        srem_q <= srem_d - strial;
        sres_q <= {sres_q[RW-2:0], 1'b1};
      end else begin
        srem_q <= srem_d;
        sres_q <= {sres_q[RW-2:0], 1'b0};
      end
    end
  end

  logic [TW-1:0] max_t;
  assign max_t = TW'(sres_q >> 1);

  // coefficient and step counters
  logic [CoeffW-1:0] a_q;
  logic [TW-1:0]     t_q;
  logic [TestsW-1:0] tests_q, own_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tests_q <= '0;
    end else if (cmd_i.count && tests_q != '1) begin
      tests_q <= tests_q + TestsW'(1);
    end
    if (cmd_i.start_coef) begin
      a_q <= lo_eff; t_q <= TW'(1); own_q <= '0;
    end else if (cmd_i.next_coef) begin
      a_q <= a_q + CoeffW'(1); t_q <= TW'(1); own_q <= '0;
    end else begin
      if (cmd_i.next_t) t_q <= t_q + TW'(1);
      if (cmd_i.count && own_q != '1) own_q <= own_q + TestsW'(1);
    end
  end

  // argument a*t*t-1, two stages; the second feeds the gcd registers directly
  logic [2*TW-1:0] tt_q;
  logic [AW-1:0]   arg_d;
  logic            mstage_q;
  assign arg_d = AW'(a_q) * AW'(tt_q) - AW'(1);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mstage_q <= 1'b0;
    else if (cmd_i.form_arg) mstage_q <= ~mstage_q;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.form_arg && !mstage_q) tt_q <= t_q * t_q;
  end

  // gcd by remainders; each remainder is a restoring division, one bit a cycle
  localparam int unsigned GW = (AW > NW) ? AW : NW;
  localparam int unsigned GCW = $clog2(GW + 1);
  logic [GW-1:0] gx_q, gy_q, gr_q, gq_q;
  logic [GCW-1:0] gcnt_q;
  logic           gdiv_q;
  logic [GW:0]    gsh;
  assign gsh = {gr_q, gq_q[GW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gdiv_q <= 1'b0;
      gcnt_q <= '0;
    end else if (cmd_i.gcd_init) begin
      gdiv_q <= 1'b0;
      gcnt_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!gdiv_q) begin
        if (gy_q != '0) begin
          gdiv_q <= 1'b1;
          gcnt_q <= GCW'(GW);
        end
      end else if (gcnt_q == GCW'(1)) begin
        gdiv_q <= 1'b0;
        gcnt_q <= '0;
      end else begin
        gcnt_q <= gcnt_q - GCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      gx_q <= GW'(n_q);
      gy_q <= GW'(arg_d);
    end else if (cmd_i.gcd_step) begin
      if (!gdiv_q) begin
        gr_q <= '0;
        gq_q <= gx_q;
      end else begin
        if (gsh >= {1'b0, gy_q}) begin
          gr_q <= GW'(gsh - {1'b0, gy_q});
        end else begin
          gr_q <= GW'(gsh);
        end
        gq_q <= {gq_q[GW-2:0], 1'b0};
        if (gcnt_q == GCW'(1)) begin
          gx_q <= gy_q;
          gy_q <= (gsh >= {1'b0, gy_q}) ? GW'(gsh - {1'b0, gy_q}) : GW'(gsh);
        end
      end
    end
  end

  assign sts_o.trivial   = (n_q < NW'(4)) || (lo_eff > hi_i);
  assign sts_o.sqrt_done = (scnt_q == '0);
  assign sts_o.t_over    = (t_q > max_t);
  assign sts_o.gcd_done  = !gdiv_q && (gy_q == '0);
  assign sts_o.hit       = (gx_q > GW'(1)) && (gx_q < GW'(n_q));
  assign sts_o.a_last    = (a_q == hi_i);
  assign sts_o.mul_done  = mstage_q;

  assign a_o     = a_q;
  assign t_o     = StepW'(t_q);
  assign g_o     = DivW'(gx_q);
  assign tests_o = tests_q;
  assign own_o   = own_q;

`ifndef SYNTHESIS
  // a division is never mid-flight when the counter is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) gdiv_q |-> gcnt_q != '0)
    else $error("gcd divider active with zero count");
  // sqrt count only falls while stepping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load && !cmd_i.sqrt_step |=> $stable(scnt_q))
    else $error("sqrt counter moved without a step");
  // tests counter never decreases while counting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count |=> tests_q >= $past(tests_q))
    else $error("tests counter went down");
`endif
endmodule
`default_nettype wire

// ===== rtl/cgfs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgfs_ctrl: search controller
// Sequences sqrt, per-coefficient loops, gcd tests and result hand-off.
// ----------------------------------------------------------------------------
module cgfs_ctrl import cgfs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire logic      mode_i,
  input  wire cgfs_sts_t sts_i,
  output      cgfs_cmd_t cmd_o,
  output      logic      out_load_o,   // capture a result word
  output      logic      out_found_o,
  output      logic      out_small_o,  // all-zero last word
  output      logic      out_last_o,
  output      logic      out_miss_seq_o,
  input  wire logic      out_free_i    // output register empty or draining
);
  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StSqrt  = 9'b000000010,
    StCheck = 9'b000000100,
    StTest  = 9'b000001000,
    StMul   = 9'b000010000,
    StGcd   = 9'b000100000,
    StJudge = 9'b001000000,
    StEmit  = 9'b010000000,
    StNext  = 9'b100000000
  } cgfs_state_e;

  cgfs_state_e state_q, state_d;
  logic        hit_q, hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    hit_d          = hit_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    out_load_o     = 1'b0;
    out_found_o    = hit_q;
    out_small_o    = 1'b0;
    out_last_o     = 1'b0;
    out_miss_seq_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSqrt;
        end
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) state_d = StCheck;
      end
      StCheck: begin
        if (sts_i.trivial) begin
          if (out_free_i) begin
            out_load_o  = 1'b1;
            out_small_o = 1'b1;
            out_last_o  = 1'b1;
            state_d     = StIdle;
          end
        end else begin
          cmd_o.start_coef = 1'b1;
          hit_d            = 1'b0;
          state_d          = StTest;
        end
      end
      StTest: begin
        if (sts_i.t_over) state_d = StEmit;
        else state_d = StMul;
      end
      StMul: begin
        cmd_o.form_arg = 1'b1;
        // gcd registers take the argument as the multiplier finishes
        if (sts_i.mul_done) begin
          cmd_o.gcd_init = 1'b1;
          state_d        = StGcd;
        end
      end
      StGcd: begin
        if (sts_i.gcd_done) begin
          cmd_o.count = 1'b1;
          state_d     = StJudge;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      StJudge: begin
        if (sts_i.hit) begin
          hit_d   = 1'b1;
          state_d = StEmit;
        end else begin
          cmd_o.next_t = 1'b1;
          state_d      = StTest;
        end
      end
      StEmit: begin
        if (mode_i) begin
          if (out_free_i) begin
            out_load_o = 1'b1;
            out_last_o = sts_i.a_last;
            state_d    = sts_i.a_last ? StIdle : StNext;
          end
        end else if (hit_q || sts_i.a_last) begin
          if (out_free_i) begin
            out_load_o     = 1'b1;
            out_last_o     = 1'b1;
            out_miss_seq_o = !hit_q;
            state_d        = StIdle;
          end
        end else begin
          state_d = StNext;
        end
      end
      StNext: begin
        cmd_o.next_coef = 1'b1;
        hit_d           = 1'b0;
        state_d         = StTest;
      end
      default: state_d = StIdle;
    endcase
  end

`ifndef SYNTHESIS
  // new numbers only taken when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle)
    else $error("input taken while busy");
  // a result word is captured only when the register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load_o |-> out_free_i)
    else $error("result overwrote pending word");
  // a hit is only judged after a finished gcd
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StJudge |-> $past(state_q) == StGcd)
    else $error("judge without gcd");
`endif
endmodule
`default_nettype wire

// ===== rtl/coefficient_gcd_factor_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coefficient_gcd_factor_search: gcd-based factor search over coefficients
// Tries gcd(n, a*t*t-1) for a in the coefficient range and t = 1..sqrt(n)/2.
// ----------------------------------------------------------------------------
// One number is searched at a time; the input is ready only while the block is
// idle, and configuration words belong between numbers. After acceptance a
// bit-serial square root runs, then a range check. Each test then checks t,
// forms a*t*t-1 in the multiplier and runs Euclid remainder steps, each a
// setup step plus a restoring-division step for each bit of the divider,
// which is as wide as the wider of the number and the a*t*t argument; the
// controller then sees the gcd finish and judges it. The gcd divider, one bit
// per cycle, dominates the search time. Results sit in a one-word output
// register, so the search goes on while a word waits to be taken and stalls
// only when the next word is ready before the waiting one has left.
module coefficient_gcd_factor_search import cgfs_pkg::*; #(
  parameter int unsigned NumberBits = NumberBitsDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cgfs_in_if.sink  in_ch,
  cgfs_out_if.source out_ch,
  cgfs_cfg_if.sink cfg_ch
);
  // configuration registers
  logic              mode_q;
  logic [CoeffW-1:0] lo_q, hi_q;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      lo_q   <= CoefLoRst;
      hi_q   <= CoefHiRst;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        RegMode:   mode_q <= cfg_ch.data[0];
        RegCoefLo: lo_q   <= cfg_ch.data[CoeffW-1:0];
        RegCoefHi: hi_q   <= cfg_ch.data[CoeffW-1:0];
        default: ;
      endcase
    end
  end

  cgfs_cmd_t cmd;
  cgfs_sts_t sts;
  logic [CoeffW-1:0] a;
  logic [StepW-1:0]  t;
  logic [DivW-1:0]   g;
  logic [TestsW-1:0] tests, own;
  logic out_load, out_found, out_small, out_last, out_miss_seq, out_free;

  cgfs_datapath #(.NumberBits(NumberBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .number_i(in_ch.number),
    .lo_i(lo_q), .hi_i(hi_q), .a_o(a), .t_o(t), .g_o(g),
    .tests_o(tests), .own_o(own)
  );

  cgfs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .mode_i(mode_q), .sts_i(sts), .cmd_o(cmd), .out_load_o(out_load),
    .out_found_o(out_found), .out_small_o(out_small), .out_last_o(out_last),
    .out_miss_seq_o(out_miss_seq), .out_free_i(out_free)
  );

  // output register
  logic ovalid_q;
  assign out_free = !ovalid_q || out_ch.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (out_load) ovalid_q <= 1'b1;
    else if (out_ch.ready) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch.found       <= out_found && !out_small;
      out_ch.coefficient <= (out_small || out_miss_seq) ? '0 : a;
      out_ch.hit_step    <= (out_found && !out_small) ? t : '0;
      out_ch.divisor     <= (out_found && !out_small) ? g : '0;
      out_ch.tests_made  <= out_small ? '0 : (mode_q ? own : tests);
      out_ch.last        <= out_last;
    end
  end
  assign out_ch.valid = ovalid_q;

`ifndef SYNTHESIS
  // a waiting word holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.divisor))
    else $error("result changed while stalled");
  // found words carry a nonzero step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.found |-> out_ch.hit_step != '0)
    else $error("hit with zero step");
  // no new number accepted while a result is being built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("back-to-back accept");
`endif
endmodule
`default_nettype wire
